// ----- rtl/core/lms_pkg.sv -----
// lms_pkg: shared types and constants for the LMS regression trainer.
// No dependencies.
`default_nettype none
package lms_pkg;
    // features per sample; the sample struct below carries this many
    localparam int NUM_FEATURES = 4;

    typedef struct packed {
        logic signed [31:0] feature_0;
        logic signed [31:0] feature_1;
        logic signed [31:0] feature_2;
        logic signed [31:0] feature_3;
        logic signed [31:0] target;
        logic               last_sample;
    } lms_in_t;

    typedef struct packed {
        logic [2:0]         weight_index;
        logic signed [31:0] weight_value;
        logic [31:0]        final_loss;
        logic [31:0]        epochs_run;
        logic               last_result;
    } lms_out_t;

    localparam logic [1:0] REG_RATE      = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_EPOCHS    = 2'd2;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_CLEAR  = 3'd1,  // zero weights, epoch count, loss accumulator
        OP_LOSS   = 3'd2,  // accumulate loss of one sample
        OP_UPDATE = 3'd3,  // apply LMS step of one sample
        OP_EPOCH  = 3'd4   // bump epoch counter
    } lms_op_t;

    typedef struct packed {
        lms_op_t op;
        logic    rd_en;     // read sample at rd_addr
        logic    div_start; // start mean division
    } lms_cmd_t;

    typedef struct packed {
        logic op_done;  // multi-cycle sample op finished
        logic div_done;
        logic stop;     // loss at/below threshold or epoch limit reached
    } lms_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        else if (v < -66'sd2147483648) return 32'sh80000000;
        else return v[31:0];
    endfunction

    // round half up then shift right 16 (arithmetic)
    function automatic logic signed [65:0] rnd16(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + 66'sd32768;
        return t >>> 16;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/lms_datapath.sv -----
// lms_datapath: sample store, weights, multiplier sequencing, loss divider.
// Depends on lms_pkg.
`default_nettype none
module lms_datapath
    import lms_pkg::*;
#(
    parameter int MAX_SAMPLES  = 256,
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    localparam int CW = $clog2(MAX_SAMPLES + 1),
    localparam int NW = NUM_FEATURES + 1
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [AW-1:0]          wr_addr,
    input  wire logic signed [NW*32-1:0] wr_data,
    input  wire logic [AW-1:0]          rd_addr,
    input  wire logic [CW-1:0]          count,
    input  wire logic [15:0]            rate,
    input  wire logic [31:0]            threshold,
    input  wire logic [31:0]            limit,
    input  wire lms_cmd_t               cmd,
    output lms_stat_t                   stat,
    input  wire logic [2:0]             out_sel,
    output logic signed [31:0]          out_weight,
    output logic [31:0]                 out_loss,
    output logic [31:0]                 out_epochs
);
    // sample memory: features at lanes 0..N-1, target at lane N
    logic signed [NW*32-1:0] mem [MAX_SAMPLES];
    logic signed [NW*32-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_reg <= mem[rd_addr];
    end

    logic signed [31:0] w_reg [NW];
    logic [31:0]        epoch_reg;
    logic [63:0]        lacc_reg;
    logic [31:0]        loss_reg;
    logic               op_done_reg;
    logic               div_done_reg;

    // per-sample sequencer: step 0..N-1 multiply-accumulate prediction,
    // then error, then (update) gradient and N feature steps
    typedef enum logic [3:0] {
        SS_IDLE = 4'b0001, SS_PRED = 4'b0010, SS_ERR = 4'b0100, SS_UPD = 4'b1000
    } ss_t;
    ss_t ss_reg;
    logic [3:0] k_reg;
    logic upd_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic               prod_v_reg;
    logic signed [31:0] e_reg;
    logic signed [31:0] g_reg;
    logic [1:0]         ph_reg;

    function automatic logic signed [31:0] lane(input logic signed [NW*32-1:0] d,
                                                 input int i);
        return d[i*32 +: 32];
    endfunction

    logic signed [31:0] xk;
    logic signed [31:0] wk;
    always_comb
    begin
        xk = 32'sd0;
        wk = 32'sd0;
        for (int i = 0; i < NUM_FEATURES; i++)
        begin
            if (k_reg == 4'(i))
            begin
                xk = lane(rd_reg, i);
                wk = w_reg[i+1];
            end
        end
    end

    logic signed [65:0] sum_ext;
    logic signed [63:0] acc_sat;
    logic signed [31:0] pred;
    logic signed [31:0] yv;
    always_comb
    begin
        sum_ext = 66'(acc_reg) + 66'(prod_reg);
        if (sum_ext > 66'sh0_7fff_ffff_ffff_ffff) acc_sat = 64'sh7fff_ffff_ffff_ffff;
        else if (sum_ext < -66'sh0_8000_0000_0000_0000) acc_sat = 64'sh8000_0000_0000_0000;
        else acc_sat = sum_ext[63:0];
        yv = lane(rd_reg, NUM_FEATURES);
    end
    logic signed [63:0] acc_clip;
    always_comb
    begin
        if (acc_reg > 64'sh4000_0000_0000_0000) acc_clip = 64'sh4000_0000_0000_0000;
        else if (acc_reg < -64'sh4000_0000_0000_0000) acc_clip = -64'sh4000_0000_0000_0000;
        else acc_clip = acc_reg;
        pred = sat32(rnd16(66'(acc_clip)));
    end

    logic [63:0] sq;
    assign sq = 64'(e_reg * e_reg) >> 1;

    // rate * e rounded to Q16.16; always fits 32 bits signed
    logic signed [65:0] g_full;
    assign g_full = rnd16(66'(64'($signed({1'b0, rate})) * 64'(e_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ss_reg      <= SS_IDLE;
            k_reg       <= '0;
            upd_reg     <= 1'b0;
            prod_v_reg  <= 1'b0;
            ph_reg      <= '0;
            epoch_reg   <= '0;
            lacc_reg    <= '0;
            op_done_reg <= 1'b0;
            for (int i = 0; i < NW; i++) w_reg[i] <= '0;
        end
        else
        begin
            op_done_reg <= ((ss_reg == SS_ERR) && (ph_reg != 2'd0) && !upd_reg)
                        || ((ss_reg == SS_UPD) && (k_reg == 4'(NUM_FEATURES))
                            && (ph_reg != 2'd0));
            unique case (ss_reg)
                SS_IDLE:
                begin
                    if (cmd.op == OP_LOSS || cmd.op == OP_UPDATE)
                    begin
                        ss_reg     <= SS_PRED;
                        upd_reg    <= (cmd.op == OP_UPDATE);
                        k_reg      <= '0;
                        acc_reg    <= 64'(w_reg[0]) <<< 16;
                        prod_reg   <= '0;
                        prod_v_reg <= 1'b0;
                    end
                end
                SS_PRED:
                begin
                    // one multiply per cycle, registered, then accumulated
                    if (prod_v_reg)
                        acc_reg <= acc_sat;
                    if (k_reg < 4'(NUM_FEATURES))
                    begin
                        prod_reg   <= 64'(xk) * 64'(wk);
                        prod_v_reg <= 1'b1;
                        k_reg      <= k_reg + 4'd1;
                    end
                    else
                    begin
                        prod_v_reg <= 1'b0;
                        if (!prod_v_reg)
                            ss_reg <= SS_ERR;
                    end
                end
                SS_ERR:
                begin
                    e_reg <= sat32(66'(yv) - 66'(pred));
                    if (ph_reg == 2'd0)
                        ph_reg <= 2'd1;
                    else
                    begin
                        ph_reg <= 2'd0;
                        if (upd_reg)
                        begin
                            g_reg  <= g_full[31:0];
                            ss_reg <= SS_UPD;
                            k_reg  <= '0;
                        end
                        else
                        begin
                            if (lacc_reg > ~64'd0 - sq) lacc_reg <= ~64'd0;
                            else lacc_reg <= lacc_reg + sq;
                            ss_reg <= SS_IDLE;
                        end
                    end
                end
                SS_UPD:
                begin
                    if (k_reg == 4'd0)
                    begin
                        w_reg[0] <= sat32(66'(w_reg[0]) + 66'(g_reg));
                        k_reg    <= 4'd1;
                        ph_reg   <= 2'd0;
                    end
                    else if (ph_reg == 2'd0)
                    begin
                        // 32x32 product registered before rounding
                        prod_reg <= 64'(g_reg) * 64'(lane(rd_reg, int'(k_reg) - 1));
                        ph_reg   <= 2'd1;
                    end
                    else
                    begin
                        for (int i = 1; i < NW; i++)
                            if (k_reg == 4'(i))
                                w_reg[i] <= sat32(66'(w_reg[i]) + rnd16(66'(prod_reg)));
                        ph_reg <= 2'd0;
                        if (k_reg == 4'(NUM_FEATURES))
                            ss_reg <= SS_IDLE;
                        k_reg <= k_reg + 4'd1;
                    end
                end
                default: ss_reg <= SS_IDLE;
            endcase

            if (cmd.op == OP_CLEAR)
            begin
                for (int i = 0; i < NW; i++) w_reg[i] <= '0;
                epoch_reg <= '0;
                lacc_reg  <= '0;
            end
            if (cmd.op == OP_EPOCH)
                epoch_reg <= epoch_reg + 32'd1;
            if (cmd.div_start)
                lacc_reg <= '0;
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [63:0] dq_reg;
    logic [CW:0] rem_reg;
    logic [6:0]  dcnt_reg;
    logic        dbusy_reg;
    logic [CW:0] trial;
    assign trial = {rem_reg[CW-1:0], dq_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg    <= 1'b0;
            dcnt_reg     <= '0;
            div_done_reg <= 1'b0;
        end
        else
        begin
            div_done_reg <= dbusy_reg && !cmd.div_start && (dcnt_reg == 7'd1);
            if (cmd.div_start)
            begin
                dq_reg    <= lacc_reg;
                rem_reg   <= '0;
                dcnt_reg  <= 7'd64;
                dbusy_reg <= 1'b1;
            end
            else if (dbusy_reg)
            begin
                if (trial >= {1'b0, count})
                begin
                    rem_reg <= trial - {1'b0, count};
                    dq_reg  <= {dq_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    dq_reg  <= {dq_reg[62:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 7'd1;
                if (dcnt_reg == 7'd1)
                    dbusy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_done_reg)
            loss_reg <= (|dq_reg[63:48]) ? 32'hffff_ffff : dq_reg[47:16];
    end

    assign stat = '{op_done: op_done_reg, div_done: div_done_reg,
                    stop: (loss_reg <= threshold) || (epoch_reg >= limit)};

    always_comb
    begin
        out_weight = w_reg[0];
        for (int i = 0; i < NW; i++)
            if (out_sel == 3'(i)) out_weight = w_reg[i];
    end
    assign out_loss   = loss_reg;
    assign out_epochs = epoch_reg;
endmodule
`default_nettype wire

// ----- rtl/core/lms_ctrl.sv -----
// lms_ctrl: training sequencer state machine.
// Depends on lms_pkg.
`default_nettype none
module lms_ctrl
    import lms_pkg::*;
#(
    parameter int MAX_SAMPLES  = 256,
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    localparam int CW = $clog2(MAX_SAMPLES + 1)
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [CW-1:0] count,
    input  wire lms_stat_t    stat,
    output lms_cmd_t          cmd,
    output logic [AW-1:0]     rd_addr,
    output logic              busy,
    output logic              emit,
    output logic [2:0]        emit_sel,
    input  wire logic         emit_taken,
    output logic              done
);
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CLEAR = 8'b0000_0010,
        ST_LRD   = 8'b0000_0100,
        ST_LOP   = 8'b0000_1000,
        ST_DIV   = 8'b0001_0000,
        ST_URD   = 8'b0010_0000,
        ST_UOP   = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } st_t;
    st_t st_reg, st_next;
    logic [CW-1:0] s_reg, s_next;
    logic [2:0] e_reg, e_next;
    logic wait_reg, wait_next;

    always_comb
    begin
        st_next   = st_reg;
        s_next    = s_reg;
        e_next    = e_reg;
        wait_next = 1'b0;
        cmd       = '{op: OP_NONE, rd_en: 1'b0, div_start: 1'b0};
        done      = 1'b0;
        unique case (st_reg)
            ST_IDLE:
                if (start)
                    st_next = ST_CLEAR;
            ST_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                s_next = '0;
                st_next = ST_LRD;
            end
            ST_LRD:
            begin
                if (s_reg == count)
                begin
                    cmd.div_start = 1'b1;
                    st_next = ST_DIV;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    st_next = ST_LOP;
                    wait_next = 1'b1;
                end
            end
            ST_LOP:
            begin
                if (wait_reg)
                    cmd.op = OP_LOSS;
                else if (stat.op_done)
                begin
                    s_next = s_reg + 1'b1;
                    st_next = ST_LRD;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    wait_next = 1'b1;
                end
                if (wait_reg)
                begin
                    if (stat.stop)
                    begin
                        e_next = '0;
                        st_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.op = OP_EPOCH;
                        s_next = '0;
                        st_next = ST_URD;
                    end
                end
            end
            ST_URD:
            begin
                if (s_reg == count)
                begin
                    s_next = '0;
                    st_next = ST_LRD;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    st_next = ST_UOP;
                    wait_next = 1'b1;
                end
            end
            ST_UOP:
            begin
                if (wait_reg)
                    cmd.op = OP_UPDATE;
                else if (stat.op_done)
                begin
                    s_next = s_reg + 1'b1;
                    st_next = ST_URD;
                end
            end
            ST_EMIT:
            begin
                if (emit_taken)
                begin
                    e_next = e_reg + 3'd1;
                    if (e_reg == 3'(NUM_FEATURES))
                    begin
                        done = 1'b1;
                        st_next = ST_IDLE;
                    end
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            s_reg    <= '0;
            e_reg    <= '0;
            wait_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            s_reg    <= s_next;
            e_reg    <= e_next;
            wait_reg <= wait_next;
        end
    end

    assign rd_addr  = s_reg[AW-1:0];
    assign busy     = (st_reg != ST_IDLE);
    assign emit     = (st_reg == ST_EMIT);
    assign emit_sel = e_reg;

    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> e_reg <= 3'(NUM_FEATURES)) else $error("emit index out of range");
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> cmd.op == OP_NONE) else $error("overlapping commands");
    a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> s_reg < count) else $error("read past fill");
endmodule
`default_nettype wire

// ----- rtl/core/lms_linear_regression_trainer_unit.sv -----
// Top level of the LMS linear regression trainer: registers, input store control,
// output register. Depends on lms_pkg, lms_ctrl, lms_datapath.
//
//  channel | signals                          | meaning
//  in      | in_valid, in_ready, in_data      | one sample item
//  out     | out_valid, out_ready, out_data   | one weight result item
//  cfg     | cfg_we, cfg_index, cfg_data      | register write, no wait
//
// Samples are taken one per cycle while loading. The item with last_sample
// starts training; input is held off until the last of the NUM_FEATURES+1
// results is loaded into the output register.
// Each epoch runs a loss pass over the samples, the bit-serial mean divider
// and stop check, and an update pass over the samples.
// Reset clears the counters and weights; the sample store is not cleared.
`default_nettype none
module lms_linear_regression_trainer_unit
    import lms_pkg::*;
#(
    parameter int MAX_SAMPLES  = 256
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire lms_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output lms_out_t      out_data,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int NW = NUM_FEATURES + 1;

    logic [15:0] rate_reg;
    logic [31:0] thr_reg;
    logic [31:0] lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= 16'd655;
            thr_reg  <= 32'd66;
            lim_reg  <= 32'd10000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RATE:      rate_reg <= cfg_data[15:0];
                REG_THRESHOLD: thr_reg  <= cfg_data;
                REG_EPOCHS:    lim_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // fill count; cleared once a run's last result is loaded for output
    logic [CW-1:0] cnt_reg;
    logic          start_reg;
    logic          busy;
    logic          accept;
    logic          full;
    logic          start;
    logic          done;
    assign in_ready = !busy && !start_reg;
    assign accept   = in_valid && in_ready;
    assign full     = (cnt_reg == CW'(MAX_SAMPLES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= accept && in_data.last_sample;
            if (accept && !full)
                cnt_reg <= cnt_reg + 1'b1;
            if (done)
                cnt_reg <= '0;
        end
    end
    assign start = start_reg;

    // lanes: features 0..N-1, target at lane N
    logic signed [NW*32-1:0] wr_data;
    logic signed [31:0] fin [NUM_FEATURES];
    assign fin[0] = in_data.feature_0;
    assign fin[1] = in_data.feature_1;
    assign fin[2] = in_data.feature_2;
    assign fin[3] = in_data.feature_3;
    always_comb
    begin
        wr_data = '0;
        for (int i = 0; i < NUM_FEATURES; i++)
            wr_data[i*32 +: 32] = fin[i];
        wr_data[NUM_FEATURES*32 +: 32] = in_data.target;
    end

    lms_cmd_t      cmd;
    lms_stat_t     stat;
    logic [AW-1:0] rd_addr;
    logic          emit;
    logic [2:0]    emit_sel;
    logic          emit_taken;
    logic signed [31:0] wv;
    logic [31:0]   lv;
    logic [31:0]   ev;

    lms_ctrl #(.MAX_SAMPLES(MAX_SAMPLES)) u_ctrl (
        .clk, .rst_n, .start, .count(cnt_reg), .stat, .cmd, .rd_addr, .busy,
        .emit, .emit_sel, .emit_taken, .done
    );

    lms_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .clk, .rst_n, .wr_en(accept && !full), .wr_addr(cnt_reg[AW-1:0]), .wr_data,
        .rd_addr, .count(cnt_reg), .rate(rate_reg), .threshold(thr_reg),
        .limit(lim_reg), .cmd, .stat, .out_sel(emit_sel), .out_weight(wv),
        .out_loss(lv), .out_epochs(ev)
    );

    // output register: loaded when empty or drained
    logic     ov_reg;
    lms_out_t od_reg;
    assign emit_taken = emit && (!ov_reg || out_ready);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (emit_taken)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (emit_taken)
        begin
            od_reg.weight_index <= emit_sel;
            od_reg.weight_value <= wv;
            od_reg.final_loss   <= lv;
            od_reg.epochs_run   <= ev;
            od_reg.last_result  <= (emit_sel == 3'(NUM_FEATURES));
        end
    end
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready) else $error("input taken while training");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_SAMPLES)) else $error("fill count overflow");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy) else $error("training did not start");
endmodule
`default_nettype wire

// ----- tb/lms_trainer_checker.sv -----
// lms_trainer_checker: watches the sample, weight and register ports of the
// LMS trainer, predicts every weight item and compares it. Depends on lms_pkg.
`timescale 1ns / 1ps
module lms_trainer_checker
    import lms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire lms_in_t     in_data,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire lms_out_t    out_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               errors,
    output int               pending
);
    localparam int STORE_DEPTH = 256;
    localparam int FEATS       = 4;

    typedef logic signed [65:0] wide_t;

    logic signed [31:0] feat_mem [STORE_DEPTH][FEATS];
    logic signed [31:0] targ_mem [STORE_DEPTH];
    int unsigned        held;
    logic signed [31:0] wts [FEATS+1];
    logic [15:0]        rate;
    logic [31:0]        stop_level;
    logic [31:0]        max_epochs;
    lms_out_t           weight_q [$];

    function automatic logic signed [31:0] clip32(input wide_t v);
        if (v > wide_t'(64'sh7fffffff)) return 32'sh7fffffff;
        if (v < -wide_t'(64'sh80000000)) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic wide_t half_up16(input wide_t v);
        wide_t t;
        t = v + 66'sd32768;
        return t >>> 16;
    endfunction

    // model output for one stored sample, Q16.16
    function automatic logic signed [31:0] fit_of(input int s);
        wide_t acc;
        wide_t hi;
        hi  = 66'sd1 <<< 62;
        acc = wide_t'(wts[0]) * 66'sd65536;
        for (int i = 0; i < FEATS; i++)
        begin
            acc = acc + wide_t'(feat_mem[s][i]) * wide_t'(wts[i+1]);
            if (acc > wide_t'(64'sh7fffffffffffffff)) acc = wide_t'(64'sh7fffffffffffffff);
            if (acc < wide_t'(64'sh8000000000000000)) acc = wide_t'(64'sh8000000000000000);
        end
        if (acc > hi) acc = hi;
        if (acc < -hi) acc = -hi;
        return clip32(half_up16(acc));
    endfunction

    function automatic wide_t err_of(input int s);
        return wide_t'(clip32(wide_t'(targ_mem[s]) - wide_t'(fit_of(s))));
    endfunction

    function automatic logic [31:0] mean_half_sq();
        logic [64:0] sum;
        logic [63:0] m;
        wide_t       e;
        sum = '0;
        for (int s = 0; s < held; s++)
        begin
            e   = err_of(s);
            sum = sum + 65'((e * e) >>> 1);
            if (sum[64]) sum = {1'b0, {64{1'b1}}};
        end
        m = (sum[63:0] / 64'(held)) >> 16;
        return (m > 64'hffffffff) ? 32'hffffffff : m[31:0];
    endfunction

    // one pass of per-sample gradient steps
    function automatic void sgd_pass();
        wide_t e, g, d;
        for (int s = 0; s < held; s++)
        begin
            e = err_of(s);
            g = half_up16(wide_t'($signed({1'b0, rate})) * e);
            wts[0] = clip32(wide_t'(wts[0]) + g);
            for (int i = 0; i < FEATS; i++)
            begin
                d = half_up16(g * wide_t'(feat_mem[s][i]));
                wts[i+1] = clip32(wide_t'(wts[i+1]) + d);
            end
        end
    endfunction

    function automatic void train_and_queue();
        logic [31:0] loss;
        logic [31:0] ep;
        lms_out_t    r;
        for (int i = 0; i <= FEATS; i++) wts[i] = '0;
        ep = '0;
        forever
        begin
            loss = mean_half_sq();
            if (loss <= stop_level || ep >= max_epochs) break;
            ep++;
            sgd_pass();
        end
        for (int i = 0; i <= FEATS; i++)
        begin
            r.weight_index = 3'(i);
            r.weight_value = wts[i];
            r.final_loss   = loss;
            r.epochs_run   = ep;
            r.last_result  = (i == FEATS);
            weight_q = {weight_q, r};
        end
        held = 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lms_out_t w;
        if (!rst_n)
        begin
            held       = 0;
            rate       = 16'd655;
            stop_level = 32'd66;
            max_epochs = 32'd10000;
            weight_q.delete();
            errors     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RATE:      rate       = cfg_data[15:0];
                    REG_THRESHOLD: stop_level = cfg_data;
                    REG_EPOCHS:    max_epochs = cfg_data;
                    default:       ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (weight_q.size() == 0)
                    report_mismatch("unexpected item, index", 32'(out_data.weight_index), '0);
                else
                begin
                    w = weight_q.pop_front();
                    if (out_data.weight_index !== w.weight_index)
                        report_mismatch("weight_index", 32'(out_data.weight_index),
                                        32'(w.weight_index));
                    if (out_data.weight_value !== w.weight_value)
                        report_mismatch("weight_value", out_data.weight_value, w.weight_value);
                    if (out_data.final_loss !== w.final_loss)
                        report_mismatch("final_loss", out_data.final_loss, w.final_loss);
                    if (out_data.epochs_run !== w.epochs_run)
                        report_mismatch("epochs_run", out_data.epochs_run, w.epochs_run);
                    if (out_data.last_result !== w.last_result)
                        report_mismatch("last_result", 32'(out_data.last_result),
                                        32'(w.last_result));
                end
            end
            if (in_valid && in_ready)
            begin
                if (held < STORE_DEPTH)
                begin
                    feat_mem[held][0] = in_data.feature_0;
                    feat_mem[held][1] = in_data.feature_1;
                    feat_mem[held][2] = in_data.feature_2;
                    feat_mem[held][3] = in_data.feature_3;
                    targ_mem[held]    = in_data.target;
                    held++;
                end
                if (in_data.last_sample) train_and_queue();
            end
        end
        pending = weight_q.size();
    end
endmodule

// ----- tb/tb_lms_linear_regression_trainer_unit.sv -----
// tb_lms_linear_regression_trainer_unit: stimulus and verdict for the LMS
// trainer. Depends on lms_pkg, the trainer RTL and lms_trainer_checker.
`timescale 1ns / 1ps
module tb_lms_linear_regression_trainer_unit;
    import lms_pkg::*;

    localparam logic [1:0] REG_SPARE  = 2'd3;     // no register behind it
    localparam int         CYCLE_CAP  = 3000000;
    localparam int         HOLD_SPAN  = 400;      // long receiver hold-off

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    lms_in_t     in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    lms_out_t    out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_RATE;
    logic [31:0] cfg_data = '0;
    int          errors;
    int          pending;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_req = 1'b0;
    int          cycles = 0;

    always #6 clk = ~clk;

    lms_linear_regression_trainer_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lms_trainer_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request; the count
    // starts once a result waits, so results back up and the sample port
    // stays closed while the sender keeps offering
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                while (!out_valid) @(posedge clk);
                repeat (HOLD_SPAN) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one item on the sample port; valid is left high after acceptance so
    // back-to-back items never lower and raise it in one step
    task automatic send_item(input lms_in_t d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
    endtask

    // close the sample port and wait for every predicted weight to leave
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // register writes only with the trainer idle; the spare index is hit too
    task automatic set_regs(input logic [15:0] rate, input logic [31:0] thr,
                            input logic [31:0] lim);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RATE;
        cfg_data  <= {16'($urandom), rate};
        @(posedge clk);
        cfg_index <= REG_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        cfg_index <= REG_EPOCHS;
        cfg_data  <= lim;
        @(posedge clk);
        cfg_index <= REG_SPARE;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_feature(input bit full_range);
        if (full_range || $urandom_range(9) == 0) return $urandom;
        return $signed($urandom_range(393216)) - 32'sd196608;   // about +-3.0
    endfunction

    // one training set of n samples; targets mostly follow a line
    task automatic send_set(input int n, input bit full_range);
        lms_in_t d;
        for (int i = 0; i < n; i++)
        begin
            d.feature_0 = pick_feature(full_range);
            d.feature_1 = pick_feature(full_range);
            d.feature_2 = pick_feature(full_range);
            d.feature_3 = pick_feature(full_range);
            if (full_range || $urandom_range(7) == 0)
                d.target = $urandom;
            else
                d.target = 32'sh10000 + (d.feature_0 >>> 1) - d.feature_2
                           + ($signed($urandom_range(8191)) - 32'sd4096);
            d.last_sample = (i == n - 1);
            send_item(d);
        end
    endtask

    initial
    begin
        lms_in_t d;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single sample at the field extremes
        set_regs(16'd32768, 32'd0, 32'd3);
        d = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sh1, 32'sh7fffffff, 1'b1};
        send_item(d);
        d = '{32'sh80000000, 32'sh7fffffff, -32'sh1, 32'sh0, 32'sh80000000, 1'b1};
        send_item(d);
        send_set(3, 1'b0);
        drain();

        // zero epoch limit: weights stay zero, loss checked once
        set_regs(16'd655, 32'd0, 32'd0);
        send_set(3, 1'b0);
        drain();

        // largest limit, stop level so high that the first check ends it
        set_regs(16'hffff, 32'hffffffff, 32'hffffffff);
        send_set(4, 1'b1);
        drain();

        // zero rate: loss never moves, epoch limit ends it
        set_regs(16'd0, 32'd0, 32'd2);
        send_set(2, 1'b0);
        drain();

        // full rate, saturating weights
        set_regs(16'hffff, 32'd0, 32'd4);
        send_set(3, 1'b1);
        send_set(3, 1'b0);
        drain();

        // random part: four idling modes, fresh settings for each round
        for (int mode = 0; mode < 4; mode++)
        begin
            send_idle_pct  = (mode == 1) ? 81 : (mode == 3) ? 36 : 0;
            recv_stall_pct = (mode == 2) ? 81 : (mode == 3) ? 36 : 0;
            for (int k = 0; k < 3; k++)
            begin
                set_regs($urandom_range(3) == 0 ? 16'($urandom) :
                             16'($urandom_range(20000, 500)),
                         $urandom_range(1) ? 32'($urandom_range(4096)) : $urandom,
                         32'($urandom_range(6)));
                if (mode == 0 && k == 1) hold_req = 1'b1;
                for (int s = 0; s < 3; s++)
                    send_set($urandom_range(7) == 0 ? 8 : $urandom_range(6, 2),
                             $urandom_range(5) == 0);
                drain();
            end
        end

        repeat (200) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
